@@ rtl/core/lru_tag_cache_top_assert.svh @@
// Assertion macros shared by the LRU tag cache RTL.
`ifndef LRU_TAG_CACHE_TOP_ASSERT_SVH
`define LRU_TAG_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ltc_pkg.sv @@
// Shared types and constants of the LRU tag cache.
package ltc_pkg;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // Width of the reported fill count (count is masked to this many bits).
    localparam int unsigned FILL_W = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } ltc_state_t;

    typedef struct packed {
        logic load_in;
        logic search;
        logic update;
    } ltc_cmd_t;

    typedef struct packed {
        logic out_free;
    } ltc_status_t;

endpackage

@@ rtl/core/ltc_datapath.sv @@
// Entry store kept in recency order, tag compare, shift update and result register.
`include "lru_tag_cache_top_assert.svh"
module ltc_datapath #(
    parameter int unsigned ENTRIES    = 5,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_func,
    input  logic [KEY_BITS-1:0]     in_key,
    input  logic [VALUE_BITS-1:0]   in_value,
    input  ltc_pkg::ltc_cmd_t       cmd,
    output ltc_pkg::ltc_status_t    status,
    input  logic                    m_tready,
    output logic                    out_valid,
    output logic                    out_hit,
    output logic [VALUE_BITS-1:0]   out_data,
    output logic                    out_evicted,
    output logic [KEY_BITS-1:0]     out_evicted_key,
    output logic [ltc_pkg::FILL_W-1:0] out_fill
);
    import ltc_pkg::*;

    localparam int unsigned POS_W = $clog2(ENTRIES);
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    // Position 0 is the most recent entry.
    logic [KEY_BITS-1:0]   key_reg [ENTRIES];
    logic [VALUE_BITS-1:0] val_reg [ENTRIES];
    logic [CNT_W-1:0]      count_reg;

    logic                  func_reg;
    logic [KEY_BITS-1:0]   in_key_reg;
    logic [VALUE_BITS-1:0] in_value_reg;

    logic                  hit_reg;
    logic [POS_W-1:0]      hit_pos_reg;

    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [VALUE_BITS-1:0] out_data_reg;
    logic                  out_evicted_reg;
    logic [KEY_BITS-1:0]   out_evicted_key_reg;
    logic [FILL_W-1:0]     out_fill_reg;

    logic                  found;
    logic [POS_W-1:0]      found_pos;
    logic                  is_insert;
    logic                  full;
    logic                  do_shift;
    logic [POS_W-1:0]      shift_pos;
    logic [KEY_BITS-1:0]   front_key;
    logic [VALUE_BITS-1:0] front_value;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W+FILL_W-1:0] count_ext;

    // Priority search: the lowest matching position is the most recent.
    always_comb
    begin
        found     = 1'b0;
        found_pos = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if ((count_reg > CNT_W'(i)) && (key_reg[i] == in_key_reg))
            begin
                found     = 1'b1;
                found_pos = POS_W'(i);
            end
        end
    end

    always_comb
    begin
        is_insert   = (func_reg == FUNC_INSERT);
        full        = (count_reg == CNT_W'(ENTRIES));
        do_shift    = is_insert || hit_reg;
        if (is_insert)
        begin
            shift_pos   = full ? POS_W'(ENTRIES - 1) : count_reg[POS_W-1:0];
            front_key   = in_key_reg;
            front_value = in_value_reg;
        end
        else
        begin
            shift_pos   = hit_pos_reg;
            front_key   = key_reg[hit_pos_reg];
            front_value = val_reg[hit_pos_reg];
        end
        count_next = count_reg + CNT_W'(is_insert && !full);
        count_ext  = (CNT_W + FILL_W)'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg     <= in_func;
            in_key_reg   <= in_key;
            in_value_reg <= in_value;
        end
        if (cmd.search)
        begin
            hit_pos_reg <= found_pos;
        end
        if (cmd.update && do_shift)
        begin
            key_reg[0] <= front_key;
            val_reg[0] <= front_value;
            for (int i = 1; i < ENTRIES; i++)
            begin
                if (POS_W'(i) <= shift_pos)
                begin
                    key_reg[i] <= key_reg[i-1];
                    val_reg[i] <= val_reg[i-1];
                end
            end
        end
        if (cmd.update)
        begin
            out_hit_reg         <= hit_reg;
            out_data_reg        <= hit_reg ? val_reg[hit_pos_reg] : '0;
            out_evicted_reg     <= is_insert && full;
            out_evicted_key_reg <= (is_insert && full) ? key_reg[ENTRIES-1] : '0;
            out_fill_reg        <= count_ext[FILL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.search)
            begin
                hit_reg <= found && (func_reg == FUNC_LOOKUP);
            end
            if (cmd.update)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;

    assign out_valid       = out_valid_reg;
    assign out_hit         = out_hit_reg;
    assign out_data        = out_data_reg;
    assign out_evicted     = out_evicted_reg;
    assign out_evicted_key = out_evicted_key_reg;
    assign out_fill        = out_fill_reg;

    `LTC_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(ENTRIES), "fill count above capacity")
    `LTC_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.update, !out_valid_reg || m_tready, "result overwritten while held")
    `LTC_ASSERT_IMPL(a_hit_on_lookup, clk, rst_n, cmd.update && hit_reg, func_reg == FUNC_LOOKUP, "hit flagged on insert")

endmodule

@@ rtl/core/ltc_ctrl.sv @@
// Sequencer for accept, search and update of one transaction at a time.
`include "lru_tag_cache_top_assert.svh"
module ltc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output ltc_pkg::ltc_cmd_t    cmd,
    input  ltc_pkg::ltc_status_t status
);
    import ltc_pkg::*;

    ltc_state_t state_reg;
    ltc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // Hold until the result register can take the outcome.
                if (status.out_free)
                begin
                    cmd.update = 1'b1;
                    s_tready   = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.load_in = 1'b1;
                        state_next  = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `LTC_ASSERT_NEXT(a_search_then_update, clk, rst_n, state_reg == ST_SEARCH, state_reg == ST_UPDATE, "search not followed by update")
    `LTC_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, (state_reg == ST_UPDATE) && !status.out_free, state_reg == ST_UPDATE, "update left while output stalled")
    `LTC_ASSERT_IMPL(a_cmd_exclusive, clk, rst_n, 1'b1, $onehot0({cmd.search, cmd.update}), "search and update together")

endmodule

@@ rtl/core/lru_tag_cache_top.sv @@
// Top level of the fully associative LRU tag cache.
//
// Usage:
//   Input stream (s_*): one transaction per operation. s_tuser is the
//   operation (0 lookup, 1 insert); s_tdata carries key and value.
//   Output stream (m_*): exactly one result per operation, in order.
//   m_tuser flags hit and eviction; m_tdata carries the stored value on a
//   hit, the evicted key on an eviction and the fill count after the
//   operation (masked to three bits).
//   An operation is registered on accept, compared with all entries in
//   ST_SEARCH, then applied to the recency order of the entry registers
//   and registered as the result in ST_UPDATE, which waits while a result
//   is held; each operation sees the order left by the last.
//   Reset empties the cache (fill count zero); entry contents are not
//   cleared and are never read before being written.
//   A stalled receiver holds the result in the output register; one more
//   operation is accepted and searched, then s_tready stays low until the
//   held result is taken.
module lru_tag_cache_top #(
    parameter int unsigned ENTRIES    = 5,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 16,
    localparam int unsigned IN_W      = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_W     =
        ((VALUE_BITS + KEY_BITS + ltc_pkg::FILL_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // key, value, zero fill
    input  logic             s_tuser,   // func
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // data_out, evicted_key, fill_count, zero fill
    output logic [1:0]       m_tuser    // hit, evicted
);
    import ltc_pkg::*;

    ltc_cmd_t              cmd;
    ltc_status_t           status;
    logic                  out_hit;
    logic [VALUE_BITS-1:0] out_data;
    logic                  out_evicted;
    logic [KEY_BITS-1:0]   out_evicted_key;
    logic [FILL_W-1:0]     out_fill;

    ltc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ltc_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_func         (s_tuser),
        .in_key          (s_tdata[KEY_BITS-1:0]),
        .in_value        (s_tdata[KEY_BITS+VALUE_BITS-1 -: VALUE_BITS]),
        .cmd             (cmd),
        .status          (status),
        .m_tready        (m_tready),
        .out_valid       (m_tvalid),
        .out_hit         (out_hit),
        .out_data        (out_data),
        .out_evicted     (out_evicted),
        .out_evicted_key (out_evicted_key),
        .out_fill        (out_fill)
    );

    assign m_tdata = OUT_W'({out_fill, out_evicted_key, out_data});
    assign m_tuser = {out_evicted, out_hit};

endmodule

@@ bench/lru_tag_cache_checker.sv @@
// Checker for the LRU tag cache: predicts each result and compares it on the output stream.
module lru_tag_cache_checker #(
    parameter int unsigned ENTRIES    = 5,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 16,
    parameter int unsigned IN_W       = 48,
    parameter int unsigned OUT_W      = 56
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // key, value, zero fill
    input  logic             s_tuser,   // func
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,   // data_out, evicted_key, fill_count, zero fill
    input  logic [1:0]       m_tuser,   // hit, evicted
    output int               fail_count,
    output int               outstanding
);
    import ltc_pkg::*;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] data;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
        logic [FILL_W-1:0]     fill;
    } cache_reply_t;

    logic [KEY_BITS-1:0]   slot_key [ENTRIES];
    logic [VALUE_BITS-1:0] slot_val [ENTRIES];
    int unsigned           recency  [ENTRIES];   // slot numbers, most recent first
    int unsigned           fill_level;
    cache_reply_t          replies_due [$];
    int                    mismatches = 0;

    // Bring the slot at recency position pos to the front.
    function automatic void move_to_front(int unsigned pos);
        int unsigned slot;
        slot = recency[pos];
        for (int unsigned j = pos; j > 0; j--)
            recency[j] = recency[j-1];
        recency[0] = slot;
    endfunction

    function automatic cache_reply_t apply_cache_op(logic func, logic [KEY_BITS-1:0] key,
                                                    logic [VALUE_BITS-1:0] value);
        cache_reply_t r;
        int unsigned  pos;
        r = '0;
        pos = 0;
        if (func == FUNC_LOOKUP)
        begin
            for (int unsigned i = 0; i < fill_level; i++)
            begin
                if (!r.hit && slot_key[recency[i]] == key)
                begin
                    r.hit  = 1'b1;
                    r.data = slot_val[recency[i]];
                    pos    = i;
                end
            end
            if (r.hit)
                move_to_front(pos);
        end
        else
        begin
            if (fill_level >= ENTRIES)
            begin
                // reuse the least recent slot and report its key
                pos           = ENTRIES - 1;
                r.evicted     = 1'b1;
                r.evicted_key = slot_key[recency[pos]];
            end
            else
            begin
                pos = fill_level;
                fill_level++;
            end
            slot_key[recency[pos]] = key;
            slot_val[recency[pos]] = value;
            move_to_front(pos);
        end
        r.fill = fill_level[FILL_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        cache_reply_t want;
        cache_reply_t got;
        if (!rst_n)
        begin
            fill_level = 0;
            for (int unsigned i = 0; i < ENTRIES; i++)
                recency[i] = i;
            replies_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.hit         = m_tuser[0];
                got.evicted     = m_tuser[1];
                got.data        = m_tdata[VALUE_BITS-1:0];
                got.evicted_key = m_tdata[VALUE_BITS +: KEY_BITS];
                got.fill        = m_tdata[VALUE_BITS+KEY_BITS +: FILL_W];
                if (replies_due.size() == 0)
                begin
                    $error("result transaction with no operation outstanding");
                    mismatches++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        mismatches++;
                    end
                    if (got.data !== want.data)
                    begin
                        $error("data_out: expected %h, got %h", want.data, got.data);
                        mismatches++;
                    end
                    if (got.evicted !== want.evicted)
                    begin
                        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                        mismatches++;
                    end
                    if (got.evicted_key !== want.evicted_key)
                    begin
                        $error("evicted_key: expected %h, got %h",
                               want.evicted_key, got.evicted_key);
                        mismatches++;
                    end
                    if (got.fill !== want.fill)
                    begin
                        $error("fill_count: expected %0d, got %0d", want.fill, got.fill);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(apply_cache_op(s_tuser, s_tdata[KEY_BITS-1:0],
                                                     s_tdata[KEY_BITS +: VALUE_BITS]));
        end
        fail_count  <= mismatches;
        outstanding <= replies_due.size();
    end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the LRU tag cache: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
    import ltc_pkg::*;

    localparam int unsigned IN_W            = 48;
    localparam int unsigned OUT_W           = 56;
    localparam int          QUIET_LIMIT     = 2000;
    localparam int          ITEMS_PER_PHASE = 535;

    logic             clk;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             s_tuser  = FUNC_LOOKUP;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;

    int          fail_count;
    int          outstanding;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    logic [31:0] key_pool [8];

    lru_tag_cache_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lru_tag_cache_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    // Present one operation and hold it until the transaction completes.
    task automatic issue(input logic func, input logic [31:0] key, input logic [15:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {value, key};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Mostly reuse a small pool so that lookups hit and duplicates build up.
    function automatic logic [31:0] pick_key();
        if ($urandom_range(99) < 12)
            return $urandom();
        return key_pool[$urandom_range(7)];
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(19))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        foreach (key_pool[i])
            key_pool[i] = $urandom();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty cache, extremes, duplicates, hit on the least recent entry, evictions
        issue(FUNC_LOOKUP, 32'h0000_0000, 16'hFFFF);
        issue(FUNC_INSERT, 32'h0000_0000, 16'hFFFF);
        issue(FUNC_LOOKUP, 32'h0000_0000, 16'h0000);
        issue(FUNC_INSERT, 32'hFFFF_FFFF, 16'h0000);
        issue(FUNC_INSERT, 32'hFFFF_FFFF, 16'h1234);
        issue(FUNC_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
        issue(FUNC_INSERT, 32'hA5A5_A5A5, 16'h5A5A);
        issue(FUNC_LOOKUP, 32'h5A5A_5A5A, 16'h0000);
        issue(FUNC_INSERT, 32'h1234_5678, 16'h0001);
        issue(FUNC_LOOKUP, 32'h0000_0000, 16'h0000);
        issue(FUNC_INSERT, 32'h8765_4321, 16'h8000);
        issue(FUNC_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
        issue(FUNC_LOOKUP, 32'h0000_5555, 16'hFFFF);
        issue(FUNC_INSERT, 32'h0000_0000, 16'h7FFF);
        issue(FUNC_LOOKUP, 32'h0000_0000, 16'h0000);
        issue(FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        issue(FUNC_INSERT, 32'h7FFF_FFFF, 16'h0000);
        issue(FUNC_INSERT, 32'h8000_0000, 16'hAAAA);
        issue(FUNC_LOOKUP, 32'hA5A5_A5A5, 16'h0000);
        issue(FUNC_LOOKUP, 32'h8000_0000, 16'h0000);
        issue(FUNC_INSERT, 32'h0000_0001, 16'h5555);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 52 : 0;
            snk_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 7 : 0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(99) < 3)
                    key_pool[$urandom_range(7)] = $urandom();
                issue(($urandom_range(99) < 40) ? FUNC_INSERT : FUNC_LOOKUP,
                      pick_key(), pick_value());
            end
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Abort when neither stream moves for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule
